/* sv/fd_pkg.sv */
// fall detector package: payload structs, register indexes and phase codes
// no dependencies; imported by the interfaces, the top level and the checker
`timescale 1ns / 1ps

package fd_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_FREEFALL_LEVEL_SQ = 3'd0;
  localparam logic [2:0] REG_IMPACT_LEVEL_SQ   = 3'd1;
  localparam logic [2:0] REG_POSTURE_LEVEL     = 3'd2;
  localparam logic [2:0] REG_WINDOW_MS         = 3'd3;
  localparam logic [2:0] REG_COOLDOWN_MS       = 3'd4;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // reset values of the registers
  localparam logic [31:0] FREEFALL_LEVEL_SQ_RST = 32'd42954916;
  localparam logic [31:0] IMPACT_LEVEL_SQ_RST   = 32'd603979776;
  localparam logic [15:0] POSTURE_LEVEL_RST     = 16'd11469;
  localparam logic [15:0] WINDOW_MS_RST         = 16'd1800;
  localparam logic [15:0] COOLDOWN_MS_RST       = 16'd5000;

  // phase codes
  localparam logic [1:0] PH_IDLE      = 2'd0;
  localparam logic [1:0] PH_FREEFALL  = 2'd1;
  localparam logic [1:0] PH_CONFIRMED = 2'd2;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic        [31:0] time_ms;
  } fd_sample_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       fall_alert;
  } fd_result_t;

endpackage

/* sv/fd_in_if.sv */
// sample channel: valid/ready handshake carrying one accelerometer sample
// depends on fd_pkg for the payload struct
`timescale 1ns / 1ps

interface fd_in_if import fd_pkg::*; ();
  logic       valid;
  logic       ready;
  fd_sample_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/fd_out_if.sv */
// result channel: valid/ready handshake carrying phase and alert
// depends on fd_pkg for the payload struct
`timescale 1ns / 1ps

interface fd_out_if import fd_pkg::*; ();
  logic       valid;
  logic       ready;
  fd_result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/fall_detector_fsm_top.sv */
// fall detector top level: sample register, squaring logic, phase machine
// depends on fd_pkg, fd_in_if and fd_out_if
`timescale 1ns / 1ps

// Usage
// sample_i takes one accelerometer sample per transfer (three signed axes
// and a millisecond timestamp); result_o returns exactly one result per
// sample, in order: the phase after that sample and a one-shot fall alert.
// Thresholds are written through cfg_we_i / cfg_idx_i / cfg_data_i while
// no sample is in flight; an index beyond the register list is ignored.
// A sample's result shows after it passes the sample register and then the
// result register. Throughput: one sample per cycle while the result is
// not stalled; the squares, the compares and the phase machine sit between
// the two registers, so consecutive samples follow without gaps.
// The whole pipeline advances together whenever the result register is
// empty or being taken, so sample_i.ready drops only while a result sits
// unread on result_o; a stalled result holds its value.
// Reset clears the phase to idle, the timestamps and alert flag to zero,
// empties the pipeline and reloads the register defaults.
module fall_detector_fsm_top import fd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  fd_in_if.sink               sample_i,
  fd_out_if.source            result_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // configuration registers
  logic [31:0] freefall_level_sq_q;
  logic [31:0] impact_level_sq_q;
  logic [15:0] posture_level_q;
  logic [15:0] window_ms_q;
  logic [15:0] cooldown_ms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freefall_level_sq_q <= FREEFALL_LEVEL_SQ_RST;
      impact_level_sq_q   <= IMPACT_LEVEL_SQ_RST;
      posture_level_q     <= POSTURE_LEVEL_RST;
      window_ms_q         <= WINDOW_MS_RST;
      cooldown_ms_q       <= COOLDOWN_MS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FREEFALL_LEVEL_SQ: freefall_level_sq_q <= cfg_data_i;
        REG_IMPACT_LEVEL_SQ:   impact_level_sq_q   <= cfg_data_i;
        REG_POSTURE_LEVEL:     posture_level_q     <= cfg_data_i[15:0];
        REG_WINDOW_MS:         window_ms_q         <= cfg_data_i[15:0];
        REG_COOLDOWN_MS:       cooldown_ms_q       <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // the pipeline moves as one whenever the result slot is free or draining
  logic adv;
  logic res_valid_q;
  assign adv            = !res_valid_q || result_o.ready;
  assign sample_i.ready = adv;

  // sample register
  logic       s0_valid_q;
  fd_sample_t s0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (adv) begin
      s0_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && sample_i.valid) begin
      s0_q <= sample_i.data;
    end
  end

  // magnitudes and squares
  function automatic logic [16:0] abs17(input logic signed [15:0] v);
    logic [16:0] ext;
    ext = {v[15], v};
    return v[15] ? (17'd0 - ext) : ext;
  endfunction

  logic [16:0] ax_abs, ay_abs, az_abs;
  logic [33:0] sqx_full, sqy_full, sqz_full;

  assign ax_abs   = abs17(s0_q.accel_x);
  assign ay_abs   = abs17(s0_q.accel_y);
  assign az_abs   = abs17(s0_q.accel_z);
  assign sqx_full = ax_abs * ax_abs;
  assign sqy_full = ay_abs * ay_abs;
  assign sqz_full = az_abs * az_abs;

  // phase machine and result register
  logic [31:0] msq;
  logic [31:0] ff_elapsed, cf_elapsed;
  logic        low_mag, high_mag, lying_flat, window_over, cooldown_over;

  // a full-scale axis squares to two to the thirty, so 31 bits suffice;
  // three squares stay below two to the thirty-two, no carry out
  assign msq = {1'b0, sqx_full[30:0]} + {1'b0, sqy_full[30:0]} + {1'b0, sqz_full[30:0]};

  logic [1:0]  phase_q, phase_d;
  logic [31:0] freefall_time_q, freefall_time_d;
  logic [31:0] confirm_time_q, confirm_time_d;
  logic        alert_done_q, alert_done_d;
  logic        alert;

  // wrapping differences so a rolled-over timestamp still measures right
  assign ff_elapsed    = s0_q.time_ms - freefall_time_q;
  assign cf_elapsed    = s0_q.time_ms - confirm_time_q;
  assign low_mag       = msq < freefall_level_sq_q;
  assign high_mag      = msq > impact_level_sq_q;
  assign lying_flat    = az_abs <= {1'b0, posture_level_q};
  assign window_over   = ff_elapsed > {16'd0, window_ms_q};
  assign cooldown_over = cf_elapsed > {16'd0, cooldown_ms_q};

  always_comb begin
    phase_d         = phase_q;
    freefall_time_d = freefall_time_q;
    confirm_time_d  = confirm_time_q;
    alert_done_d    = alert_done_q;
    alert           = 1'b0;
    case (phase_q)
      PH_FREEFALL: begin
        if (window_over) begin
          phase_d = PH_IDLE;
        end else if (high_mag) begin
          if (lying_flat) begin
            phase_d        = PH_CONFIRMED;
            confirm_time_d = s0_q.time_ms;
            alert_done_d   = 1'b0;
          end else begin
            phase_d = PH_IDLE;
          end
        end
      end
      PH_CONFIRMED: begin
        if (!alert_done_q) begin
          alert        = 1'b1;
          alert_done_d = 1'b1;
        end
        if (cooldown_over) begin
          phase_d = PH_IDLE;
        end
      end
      default: begin
        // idle, and the unused code behaves as idle
        phase_d = PH_IDLE;
        if (low_mag) begin
          phase_d         = PH_FREEFALL;
          freefall_time_d = s0_q.time_ms;
        end
      end
    endcase
  end

  fd_result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_IDLE;
      freefall_time_q <= 32'd0;
      confirm_time_q  <= 32'd0;
      alert_done_q    <= 1'b0;
      res_valid_q     <= 1'b0;
    end else if (adv) begin
      res_valid_q <= s0_valid_q;
      if (s0_valid_q) begin
        phase_q         <= phase_d;
        freefall_time_q <= freefall_time_d;
        confirm_time_q  <= confirm_time_d;
        alert_done_q    <= alert_done_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s0_valid_q) begin
      res_q.phase      <= phase_d;
      res_q.fall_alert <= alert;
    end
  end

  assign result_o.valid = res_valid_q;
  assign result_o.data  = res_q;

endmodule

/* sv/fd_checker.sv */
// port-level checks for the fall detector, bound to the top level
// depends on fd_pkg and fall_detector_fsm_top
`timescale 1ns / 1ps

module fd_checker import fd_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_phase,
  input logic       out_alert
);

  // an alert only comes from a confirmed-phase sample, never in free-fall
  a_alert_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_alert) |-> (out_phase != PH_FREEFALL))
    else $error("fall alert reported with free-fall phase");

  // the sample side is held back only by an unread result
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (out_valid && !out_ready))
    else $error("sample side stalled without a waiting result");

  // nothing is offered while reset is held
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid)
    else $error("result offered during reset");

  // a stalled result stays offered and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_phase) && $stable(out_alert)))
    else $error("stalled result changed or dropped");

endmodule

bind fall_detector_fsm_top fd_checker u_fd_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (sample_i.ready),
  .out_valid (result_o.valid),
  .out_ready (result_o.ready),
  .out_phase (result_o.data.phase),
  .out_alert (result_o.data.fall_alert)
);
